/* src/rtp_payload_packetizer_top_assert.svh */
// ---------------------------------------------------------------------------
// RTP payload packetizer assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RTP_PAYLOAD_PACKETIZER_TOP_ASSERT_SVH
`define RTP_PAYLOAD_PACKETIZER_TOP_ASSERT_SVH

// same-cycle implication
`define RTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rtp_pkt_pkg.sv */
// ---------------------------------------------------------------------------
// RTP packetizer package
// Shared types, constants and the header byte function.
// ---------------------------------------------------------------------------
package rtp_pkt_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int IDX_W        = 4;
    localparam logic [IDX_W-1:0] PAYLOAD_IDX = IDX_W'(HEADER_BYTES);

    localparam logic [10:0] CHUNK_MAX   = 11'd1488;
    localparam logic [10:0] CHUNK_RESET = 11'd1400;
    localparam logic [6:0]  KIND_RESET  = 7'd96;
    localparam logic [1:0]  RTP_VERSION = 2'd2;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_SOURCE_ID    = 2'd0;
    localparam logic [1:0] REG_PAYLOAD_KIND = 2'd1;
    localparam logic [1:0] REG_CHUNK_SIZE   = 2'd2;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        frame_start;
        logic [23:0] frame_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] source_id;
        logic [6:0]  payload_kind;
        logic [10:0] chunk_size;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        packet_end;
        logic        hdr;
        logic        marker;
        logic [15:0] seq;
    } job_t;

    function automatic logic [7:0] hdr_byte(
        input logic [IDX_W-1:0] idx,
        input logic             marker,
        input logic [6:0]       kind,
        input logic [15:0]      seq,
        input logic [31:0]      ssrc
    );
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = {RTP_VERSION, 6'd0};
            4'd1:    b = {marker, kind};
            4'd2:    b = seq[15:8];
            4'd3:    b = seq[7:0];
            4'd8:    b = ssrc[31:24];
            4'd9:    b = ssrc[23:16];
            4'd10:   b = ssrc[15:8];
            4'd11:   b = ssrc[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

/* src/rtp_payload_packetizer_top.sv */
// ---------------------------------------------------------------------------
// RTP payload packetizer
// Cuts frames into RTP packets with 12-byte headers, one byte per item.
// ---------------------------------------------------------------------------
// Accepts one payload byte per cycle and emits one byte per cycle unless
// out_ready stalls it. A byte that continues an open packet leaves as one
// output item; a byte that opens a packet leaves as 13 items (12 header
// bytes, then the byte), so input stalls while the header goes out. Bytes
// pass the input, job and output registers; the byte-wide output register
// sets the rate. Length-zero frames and bytes outside frames make no output.
module rtp_payload_packetizer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rtp_pkt_pkg::in_item_t          in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rtp_pkt_pkg::out_item_t         out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rtp_pkt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    rtp_pkt_pkg::cfg_t cfg;
    rtp_pkt_pkg::job_t job;
    logic              job_valid;
    logic              job_ready;

    rtp_pkt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rtp_pkt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    rtp_pkt_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* src/rtp_pkt_cfg.sv */
// ---------------------------------------------------------------------------
// RTP packetizer configuration registers
// APB-style register file holding SSRC, payload type and chunk size.
// ---------------------------------------------------------------------------
module rtp_pkt_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtp_pkt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output rtp_pkt_pkg::cfg_t             cfg
);

    rtp_pkt_pkg::cfg_t cfg_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_id    <= 32'd0;
            cfg_reg.payload_kind <= rtp_pkt_pkg::KIND_RESET;
            cfg_reg.chunk_size   <= rtp_pkt_pkg::CHUNK_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                rtp_pkt_pkg::REG_SOURCE_ID:    cfg_reg.source_id    <= pwdata;
                rtp_pkt_pkg::REG_PAYLOAD_KIND: cfg_reg.payload_kind <= pwdata[6:0];
                rtp_pkt_pkg::REG_CHUNK_SIZE:   cfg_reg.chunk_size   <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rtp_pkt_pkg::REG_SOURCE_ID:    prdata = cfg_reg.source_id;
            rtp_pkt_pkg::REG_PAYLOAD_KIND: prdata = {25'd0, cfg_reg.payload_kind};
            rtp_pkt_pkg::REG_CHUNK_SIZE:   prdata = {21'd0, cfg_reg.chunk_size};
            default:                       prdata = 32'd0;
        endcase
    end

endmodule

/* src/rtp_pkt_ctrl.sv */
// ---------------------------------------------------------------------------
// RTP packetizer frame control
// Input register, frame and packet counters, sequence number, job hand-off.
// ---------------------------------------------------------------------------
module rtp_pkt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rtp_pkt_pkg::in_item_t in_data,
    input  rtp_pkt_pkg::cfg_t     cfg,
    output logic                  job_valid,
    input  logic                  job_ready,
    output rtp_pkt_pkg::job_t     job
);

    rtp_pkt_pkg::in_item_t in_reg;
    logic                  in_valid_reg;
    logic [15:0]           seq_reg;
    logic [15:0]           seq_next;
    logic [23:0]           frame_left_reg;
    logic [23:0]           frame_left_next;
    logic [10:0]           pkt_left_reg;
    logic [10:0]           pkt_left_next;

    logic [23:0] fl;
    logic [10:0] pl;
    logic [10:0] chunk;
    logic [10:0] pl_new;
    logic        drop;
    logic        need_hdr;
    logic        marker;
    logic        take;
    logic        pkt_fits;

    always_comb
    begin
        fl   = in_reg.frame_start ? in_reg.frame_length : frame_left_reg;
        pl   = in_reg.frame_start ? 11'd0 : pkt_left_reg;
        drop = (fl == 24'd0);

        if (cfg.chunk_size == 11'd0)
            chunk = 11'd1;
        else if (cfg.chunk_size > rtp_pkt_pkg::CHUNK_MAX)
            chunk = rtp_pkt_pkg::CHUNK_MAX;
        else
            chunk = cfg.chunk_size;

        need_hdr = (pl == 11'd0) || ({13'd0, pl} > fl);
        marker   = (fl <= {13'd0, chunk});

        if (!need_hdr)
            pl_new = pl;
        else if (marker)
            pl_new = fl[10:0];
        else
            pl_new = chunk;
    end

    assign job_valid = in_valid_reg && !drop;
    assign take      = in_valid_reg && (drop || job_ready);
    assign in_ready  = !in_valid_reg || take;

    assign job.payload_byte = in_reg.payload_byte;
    assign job.packet_end   = (pl_new == 11'd1);
    assign job.hdr          = need_hdr;
    assign job.marker       = marker;
    assign job.seq          = seq_reg;

    always_comb
    begin
        seq_next        = seq_reg;
        frame_left_next = frame_left_reg;
        pkt_left_next   = pkt_left_reg;
        if (take)
        begin
            if (drop)
            begin
                frame_left_next = fl;
                pkt_left_next   = pl;
            end
            else
            begin
                frame_left_next = fl - 24'd1;
                pkt_left_next   = pl_new - 11'd1;
                seq_next        = seq_reg + {15'd0, need_hdr};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            seq_reg        <= 16'd0;
            frame_left_reg <= 24'd0;
            pkt_left_reg   <= 11'd0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            seq_reg        <= seq_next;
            frame_left_reg <= frame_left_next;
            pkt_left_reg   <= pkt_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= in_data;
    end

    assign pkt_fits = ({13'd0, pkt_left_reg} <= frame_left_reg);

`include "rtp_payload_packetizer_top_assert.svh"

    `RTP_ASSERT_NOW(a_pkt_within_frame, 1'b1, pkt_fits, "packet count exceeds frame count")
    `RTP_ASSERT_NEXT(a_seq_only_on_hdr, !(job_valid && job_ready && job.hdr), $stable(seq_reg), "sequence moved without header")
    `RTP_ASSERT_NEXT(a_item_held, in_valid_reg && !take, in_valid_reg && $stable(in_reg), "stalled item lost")

endmodule

/* src/rtp_pkt_emit.sv */
// ---------------------------------------------------------------------------
// RTP packetizer byte emitter
// Serializes header and payload bytes of a job into the output register.
// ---------------------------------------------------------------------------
module rtp_pkt_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  rtp_pkt_pkg::job_t      job,
    input  rtp_pkt_pkg::cfg_t      cfg,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rtp_pkt_pkg::out_item_t out_data
);

    rtp_pkt_pkg::job_t              job_reg;
    logic                           job_valid_reg;
    logic [rtp_pkt_pkg::IDX_W-1:0]  idx_reg;
    logic                           out_valid_reg;
    rtp_pkt_pkg::out_item_t         out_data_reg;
    rtp_pkt_pkg::out_item_t         out_data_next;

    logic slot_free;
    logic last_step;
    logic emit;

    assign slot_free = !out_valid_reg || out_ready;
    assign last_step = (idx_reg == rtp_pkt_pkg::PAYLOAD_IDX);
    assign emit      = job_valid_reg && slot_free;
    assign job_ready = !job_valid_reg || (emit && last_step);

    always_comb
    begin
        if (last_step)
        begin
            out_data_next.out_byte   = job_reg.payload_byte;
            out_data_next.packet_end = job_reg.packet_end;
            out_data_next.run_last   = 1'b1;
        end
        else
        begin
            out_data_next.out_byte   = rtp_pkt_pkg::hdr_byte(idx_reg, job_reg.marker,
                                           cfg.payload_kind, job_reg.seq, cfg.source_id);
            out_data_next.packet_end = 1'b0;
            out_data_next.run_last   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
            begin
                job_valid_reg <= job_valid;
                if (job_valid)
                    idx_reg <= job.hdr ? '0 : rtp_pkt_pkg::PAYLOAD_IDX;
            end
            else if (emit)
                idx_reg <= idx_reg + 1'b1;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_ready && job_valid)
            job_reg <= job;
        if (emit)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`include "rtp_payload_packetizer_top_assert.svh"

    `RTP_ASSERT_NOW(a_hdr_no_end, out_valid_reg && !out_data_reg.run_last, !out_data_reg.packet_end, "packet end on header byte")
    `RTP_ASSERT_NOW(a_idx_range, job_valid_reg, idx_reg <= rtp_pkt_pkg::PAYLOAD_IDX, "byte index out of range")
    `RTP_ASSERT_NEXT(a_idx_hold, job_valid_reg && !slot_free, $stable(idx_reg) && job_valid_reg, "byte index moved while stalled")

endmodule

/* tb/sv/rtp_stream_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RTP stream checker
// Watches the input, output and register ports of the packetizer, predicts
// the header and payload bytes of every packet, and compares each output item
// field by field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module rtp_stream_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  rtp_pkt_pkg::in_item_t          in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  rtp_pkt_pkg::out_item_t         out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rtp_pkt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    output int                             mismatches,
    output int                             bytes_owed
);

    logic [31:0]            ssrc;
    logic [6:0]             ptype;
    logic [10:0]            chunk;
    logic [15:0]            next_seq;
    logic [23:0]            frame_left;
    logic [10:0]            packet_left;
    rtp_pkt_pkg::out_item_t owed_q[$];
    int                     errors = 0;

    task automatic packetize(input rtp_pkt_pkg::in_item_t item);
        logic [10:0] eff;
        logic        marker;
        logic [95:0] hdr;
        if (item.frame_start) begin
            frame_left  = item.frame_length;
            packet_left = '0;
            if (item.frame_length == '0)
                return;
        end
        else if (frame_left == '0) begin
            return;
        end
        if (packet_left == '0 || packet_left > frame_left) begin
            if (chunk == '0)
                eff = 11'd1;
            else if (chunk > rtp_pkt_pkg::CHUNK_MAX)
                eff = rtp_pkt_pkg::CHUNK_MAX;
            else
                eff = chunk;
            marker = (frame_left <= {13'd0, eff});
            hdr = {rtp_pkt_pkg::RTP_VERSION, 6'd0, marker, ptype, next_seq, 32'd0, ssrc};
            for (int i = 0; i < rtp_pkt_pkg::HEADER_BYTES; i++)
                owed_q.push_back({hdr[95-8*i -: 8], 1'b0, 1'b0});
            next_seq    = next_seq + 16'd1;
            packet_left = marker ? frame_left[10:0] : eff;
        end
        owed_q.push_back({item.payload_byte, packet_left == 11'd1, 1'b1});
        packet_left = packet_left - 11'd1;
        frame_left  = frame_left - 24'd1;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %02h, actual %02h",
                     $time, name, want, got);
        end
    endtask

    task automatic check_item(input rtp_pkt_pkg::out_item_t got);
        rtp_pkt_pkg::out_item_t want;
        if (owed_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected item: expected none, actual %02h/%0b/%0b",
                     $time, got.out_byte, got.packet_end, got.run_last);
            return;
        end
        want = owed_q.pop_front();
        compare_field("out_byte", want.out_byte, got.out_byte);
        compare_field("packet_end", {7'd0, want.packet_end}, {7'd0, got.packet_end});
        compare_field("run_last", {7'd0, want.run_last}, {7'd0, got.run_last});
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ssrc        = '0;
            ptype       = rtp_pkt_pkg::KIND_RESET;
            chunk       = rtp_pkt_pkg::CHUNK_RESET;
            next_seq    = '0;
            frame_left  = '0;
            packet_left = '0;
            owed_q.delete();
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[rtp_pkt_pkg::ADDR_W-1:2])
                    rtp_pkt_pkg::REG_SOURCE_ID:    ssrc  = pwdata;
                    rtp_pkt_pkg::REG_PAYLOAD_KIND: ptype = pwdata[6:0];
                    rtp_pkt_pkg::REG_CHUNK_SIZE:   chunk = pwdata[10:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                check_item(out_data);
            if (in_valid && in_ready)
                packetize(in_data);
        end
        mismatches <= errors;
        bytes_owed <= owed_q.size();
    end

endmodule

/* tb/sv/rtp_payload_packetizer_top_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RTP payload packetizer testbench
// Drives directed and random frames through the packetizer under random
// sender gaps and receiver stalls, reprograms the registers between phases,
// and leaves all prediction and comparison to the stream checker.
// ---------------------------------------------------------------------------
module rtp_payload_packetizer_top_tb;

    localparam int         ITEM_TARGET    = 320;
    localparam int         SETTLE_CYCLES  = 12;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] REG_SPARE      = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    rtp_pkt_pkg::in_item_t          in_data;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    rtp_pkt_pkg::out_item_t         out_data;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [rtp_pkt_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    int          mismatches;
    int          bytes_owed;
    int          stall_cycles = 0;
    int          payload_sent = 0;
    int          ready_run = 0;
    int          ready_gap;
    bit          dense = 1'b0;
    logic [10:0] cur_chunk = rtp_pkt_pkg::CHUNK_RESET;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rtp_payload_packetizer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    rtp_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .bytes_owed (bytes_owed)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [23:0] pick_len();
        logic [10:0] eff;
        int          r;
        if (cur_chunk == '0)
            eff = 11'd1;
        else if (cur_chunk > rtp_pkt_pkg::CHUNK_MAX)
            eff = rtp_pkt_pkg::CHUNK_MAX;
        else
            eff = cur_chunk;
        r = $urandom_range(0, 99);
        if (eff > 11'd64 || r < 40)
            return 24'($urandom_range(1, 20));
        if (r < 55)
            return {13'd0, eff};
        if (r < 70)
            return {13'd0, eff} + 24'd1;
        if (r < 80 && eff > 11'd1)
            return {13'd0, eff} - 24'd1;
        if (r < 90)
            return {12'd0, eff, 1'b0};
        return 24'($urandom_range(1, 3 * int'(eff)));
    endfunction

    always @(posedge clk) begin
        if (ready_run > 0) begin
            ready_run <= ready_run - 1;
        end
        else if (out_ready) begin
            ready_gap = pick_gap();
            if (ready_gap > 0) begin
                out_ready <= 1'b0;
                ready_run <= ready_gap - 1;
            end
            else begin
                ready_run <= ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 30);
            end
        end
        else begin
            out_ready <= 1'b1;
            ready_run <= $urandom_range(0, 30);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("rtp_payload_packetizer_top test failed");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send(input rtp_pkt_pkg::in_item_t item);
        int gap;
        gap = dense ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_frame(input logic [23:0] len, input int count);
        for (int k = 0; k < count; k++)
            send({8'($urandom), k == 0, (k == 0) ? len : 24'($urandom)});
        if (len != '0)
            payload_sent += count;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] ssrc, input logic [6:0] kind,
                             input logic [10:0] chunk);
        drain();
        write_reg(rtp_pkt_pkg::REG_SOURCE_ID, ssrc);
        write_reg(rtp_pkt_pkg::REG_PAYLOAD_KIND, {25'd0, kind});
        write_reg(rtp_pkt_pkg::REG_CHUNK_SIZE, {21'd0, chunk});
        cur_chunk = chunk;
    endtask

    initial begin
        int          r;
        int          n;
        logic [23:0] len;
        logic [31:0] ssrc;
        logic [6:0]  kind;
        logic [10:0] chunk;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send({8'hAA, 1'b0, 24'd0});
        send({8'h55, 1'b1, 24'd0});
        send({8'h00, 1'b1, 24'd3});
        send({8'hFF, 1'b0, 24'hFFFFFF});
        send({8'h5A, 1'b0, 24'd0});
        send({8'hFF, 1'b1, 24'hFFFFFF});
        send_frame(24'hFFFFFF, 2);
        send_frame(24'd2, 2);
        send_frame(24'd5, 1);
        send({8'h3C, 1'b1, 24'd0});
        send({8'hC3, 1'b0, 24'hFFFFFF});

        configure(32'hFFFF_FFFF, 7'h7F, 11'd1);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_frame(24'd3, 3);
        configure(32'h0, 7'h00, 11'd0);
        send_frame(24'd2, 2);
        configure(32'hA5A5_5A5A, 7'h55, 11'd4);
        send_frame(24'd6, 2);
        configure(32'hA5A5_5A5A, 7'h55, 11'h7FF);
        for (int k = 0; k < 4; k++)
            send({8'($urandom), 1'b0, 24'($urandom)});

        while (payload_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            chunk = (r < 45) ? 11'($urandom_range(1, 8)) :
                    (r < 65) ? 11'($urandom_range(9, 40)) :
                    (r < 72) ? 11'd0 :
                    (r < 79) ? rtp_pkt_pkg::CHUNK_MAX :
                    (r < 86) ? 11'h7FF :
                    (r < 93) ? rtp_pkt_pkg::CHUNK_RESET : 11'($urandom);
            r = $urandom_range(0, 99);
            ssrc = (r < 10) ? 32'h0 : (r < 20) ? 32'hFFFF_FFFF : $urandom;
            r = $urandom_range(0, 99);
            kind = (r < 10) ? 7'h00 : (r < 20) ? 7'h7F : 7'($urandom);
            configure(ssrc, kind, chunk);

            repeat ($urandom_range(3, 8)) begin
                dense = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    len = pick_len();
                    send_frame(len, int'(len));
                end
                else if (r < 78) begin
                    len = 24'($urandom_range(1, 24'hFFFFFF));
                    n = $urandom_range(1, 6);
                    send_frame(len, (n > int'(len)) ? int'(len) : n);
                end
                else if (r < 85) begin
                    len = pick_len() + 24'd1;
                    send_frame(len, int'($urandom_range(1, 32'(len - 24'd1))));
                end
                else if (r < 90) begin
                    send({8'($urandom), 1'b1, 24'd0});
                end
                else if (r < 95) begin
                    send({8'($urandom), 1'b0, 24'($urandom)});
                end
                else begin
                    drain();
                end
            end
            dense = 1'b0;
        end

        drain();
        if (mismatches == 0 && bytes_owed == 0)
            $display("rtp_payload_packetizer_top test passed");
        else
            $display("rtp_payload_packetizer_top test failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/rtp_pkt_pkg.sv
src/rtp_pkt_cfg.sv
src/rtp_pkt_ctrl.sv
src/rtp_pkt_emit.sv
src/rtp_payload_packetizer_top.sv
tb/sv/rtp_stream_checker.sv
tb/sv/rtp_payload_packetizer_top_tb.sv
